@@ rtl/pcc_pkg.sv @@
// shared constants and types for the claim/complete interrupt controller
package pcc_pkg;

    localparam int NUM_SOURCES = 8;
    localparam int SRC_W       = $clog2(NUM_SOURCES);
    localparam int PRI_W       = 3;
    localparam int PRI_STORE_W = 4;

    localparam logic [24:0] WINDOW_SIZE   = 25'h1000000;
    localparam logic [23:0] PRIO_END      = 24'(NUM_SOURCES * 4);
    localparam logic [23:0] PENDING_OFF   = 24'h001000;
    localparam logic [23:0] ENABLE_OFF    = 24'h002000;
    localparam logic [23:0] THRESHOLD_OFF = 24'h200000;
    localparam logic [23:0] CLAIM_OFF     = 24'h200004;

    typedef struct packed {
        logic             vld;
        logic             en;
        logic [SRC_W-1:0] idx;
    } t_scan_step;

endpackage

@@ rtl/pcc_claim_arb.sv @@
// claim arbiter: compares one source per cycle against the best so far
module pcc_claim_arb
    import pcc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [31:0]      i_threshold,
    input  t_scan_step       i_step,
    input  logic [PRI_W-1:0] i_pri,
    output logic [SRC_W-1:0] o_best_id
);

    logic [31:0]      r_lead_pri;
    logic [SRC_W-1:0] r_best_id;
    logic             win;

    assign win       = i_step.vld && i_step.en &&
                       ({{(32-PRI_W){1'b0}}, i_pri} > r_lead_pri);
    assign o_best_id = r_best_id;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead_pri <= '0;
            r_best_id  <= '0;
        end else if (i_start) begin
            r_lead_pri <= i_threshold;
            r_best_id  <= '0;
        end else if (win) begin
            r_lead_pri <= {{(32-PRI_W){1'b0}}, i_pri};
            r_best_id  <= i_step.idx;
        end
    end

`ifndef NO_ASSERTIONS
    a_best_above_thr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        win |=> (r_best_id != '0))
        else $error("winning source id is zero");
    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> (r_best_id == '0))
        else $error("start did not clear best id");
    a_best_ranked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_start && win) |=> (r_lead_pri > $past(r_lead_pri)))
        else $error("best priority did not rise on a win");
`endif

endmodule

@@ rtl/plic_claim_complete_regs_top.sv @@
// top level: register window, priority memory, claim sequencer and result register
// Single-context interrupt controller. One bus access is taken per item and
// answered with one result item; the block takes no new item until the
// current one is finished, but a finished result may wait in the output
// register while the next item is taken. Ordinary accesses pass through an
// execute state (the registered memory read or the write) and a result state
// on their way to the output register. A claim read with the interrupt line high
// instead passes through a scan state, a drain state and the result state:
// the priority memory has one read port, the arbiter compares one source per
// cycle over sources 1 to NUM_SOURCES-1, and the drain state takes the last
// compare. A stalled output holds the block in its result state until the
// waiting result is taken.
module plic_claim_complete_regs_top
    import pcc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_op,
    input  logic [23:0] i_offset,
    input  logic [3:0]  i_length,
    input  logic [31:0] i_wdata,
    input  logic        i_meip_level,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_accepted,
    output logic [31:0] o_rdata,
    output logic        o_meip_clear
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    localparam logic [2:0] REG_NONE  = 3'd0;
    localparam logic [2:0] REG_PRIO  = 3'd1;
    localparam logic [2:0] REG_PEND  = 3'd2;
    localparam logic [2:0] REG_EN    = 3'd3;
    localparam logic [2:0] REG_THR   = 3'd4;
    localparam logic [2:0] REG_CLAIM = 3'd5;

    localparam logic [SRC_W-1:0] SCAN_FIRST = SRC_W'(1);
    localparam logic [SRC_W-1:0] SCAN_LAST  = SRC_W'(NUM_SOURCES - 1);

    logic [2:0]       r_state, n_state;
    logic             r_op, r_acc, r_level;
    logic [2:0]       r_region;
    logic [31:0]      r_wdata, r_mask;
    logic [SRC_W-1:0] r_pidx, r_scan_addr;
    logic [31:0]      r_enable, r_thr, r_pend;
    logic [SRC_W-1:0] r_in_service;
    logic [NUM_SOURCES-1:0] src_en;

    logic [PRI_STORE_W-1:0] r_pri_mem [NUM_SOURCES];
    logic [NUM_SOURCES-1:0] r_pri_vld;
    logic [PRI_STORE_W-1:0] r_pri_q;
    logic [SRC_W-1:0]       rd_addr;

    t_scan_step       r_step;
    logic [SRC_W-1:0] best_id;

    logic             r_out_valid, r_accepted, r_meip_clear;
    logic [31:0]      r_rdata;

    logic             in_take, acc_now, claim_rd, load_out, out_take;
    logic [2:0]       region_now;
    logic [31:0]      mask_now, rd_val, res_rdata;

    assign o_stall      = (r_state != S_IDLE);
    assign in_take      = i_valid && !o_stall;
    assign o_valid      = r_out_valid;
    assign o_accepted   = r_accepted;
    assign o_rdata      = r_rdata;
    assign o_meip_clear = r_meip_clear;
    assign out_take     = r_out_valid && !i_stall;
    assign load_out     = (r_state == S_DONE) && (!r_out_valid || !i_stall);

    // access decode
    assign acc_now = (i_offset[1:0] == 2'b00) &&
                     (({1'b0, i_offset} + {21'b0, i_length}) <= WINDOW_SIZE);

    always_comb begin
        case (i_length)
            4'd0:    mask_now = 32'h0000_0000;
            4'd1:    mask_now = 32'h0000_00FF;
            4'd2:    mask_now = 32'h0000_FFFF;
            4'd3:    mask_now = 32'h00FF_FFFF;
            default: mask_now = 32'hFFFF_FFFF;
        endcase
    end

    always_comb begin
        if (!acc_now) begin
            region_now = REG_NONE;
        end else if (i_offset == CLAIM_OFF) begin
            region_now = REG_CLAIM;
        end else if (i_offset < PRIO_END) begin
            region_now = REG_PRIO;
        end else if (i_offset == PENDING_OFF) begin
            region_now = REG_PEND;
        end else if (i_offset == ENABLE_OFF) begin
            region_now = REG_EN;
        end else if (i_offset == THRESHOLD_OFF) begin
            region_now = REG_THR;
        end else begin
            region_now = REG_NONE;
        end
    end

    assign claim_rd = (region_now == REG_CLAIM) && !i_op && i_meip_level;

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_take) n_state = claim_rd ? S_SCAN : S_EXEC;
            S_EXEC:  n_state = S_DONE;
            S_SCAN:  if (r_scan_addr == SCAN_LAST) n_state = S_DRAIN;
            S_DRAIN: n_state = S_DONE;
            S_DONE:  if (load_out) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op     <= i_op;
            r_acc    <= acc_now;
            r_level  <= i_meip_level;
            r_region <= region_now;
            r_wdata  <= i_wdata & mask_now;
            r_mask   <= mask_now;
            r_pidx   <= i_offset[SRC_W+1:2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_scan_addr <= SCAN_FIRST;
        end else if (r_state == S_SCAN) begin
            r_scan_addr <= r_scan_addr + SRC_W'(1);
        end
    end

    // priority memory, one read port
    assign rd_addr = (r_state == S_SCAN) ? r_scan_addr : r_pidx;

    always_ff @(posedge i_clk) begin
        if ((r_state == S_EXEC) && r_op && (r_region == REG_PRIO)) begin
            r_pri_mem[r_pidx] <= r_wdata[PRI_STORE_W-1:0];
        end
        r_pri_q <= r_pri_vld[rd_addr] ? r_pri_mem[rd_addr] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pri_vld <= '0;
        end else if ((r_state == S_EXEC) && r_op && (r_region == REG_PRIO)) begin
            r_pri_vld[r_pidx] <= 1'b1;
        end
    end

    // word registers and in-service id
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable     <= '0;
            r_thr        <= '0;
            r_pend       <= '0;
            r_in_service <= '0;
        end else begin
            if ((r_state == S_EXEC) && r_op) begin
                unique case (r_region)
                    REG_PEND:  r_pend   <= r_wdata;
                    REG_EN:    r_enable <= r_wdata;
                    REG_THR:   r_thr    <= r_wdata;
                    REG_CLAIM: if (r_wdata == {{(32-SRC_W){1'b0}}, r_in_service})
                                   r_in_service <= '0;
                    default:   ;
                endcase
            end
            if (load_out && !r_op && r_level && (r_region == REG_CLAIM)) begin
                r_in_service <= best_id;
            end
        end
    end

    // scan step into the arbiter, aligned with the memory read data
    assign src_en = r_enable[NUM_SOURCES-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else begin
            r_step.vld <= (r_state == S_SCAN);
            r_step.en  <= src_en[r_scan_addr];
            r_step.idx <= r_scan_addr;
        end
    end

    pcc_claim_arb u_arb (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (in_take),
        .i_threshold (r_thr),
        .i_step      (r_step),
        .i_pri       (r_pri_q[PRI_W-1:0]),
        .o_best_id   (best_id)
    );

    // result
    always_comb begin
        case (r_region)
            REG_PRIO:  rd_val = {{(32-PRI_STORE_W){1'b0}}, r_pri_q};
            REG_PEND:  rd_val = r_pend;
            REG_EN:    rd_val = r_enable;
            REG_THR:   rd_val = r_thr;
            REG_CLAIM: rd_val = r_level ? {{(32-SRC_W){1'b0}}, best_id} : 32'h0;
            default:   rd_val = 32'h0;
        endcase
        res_rdata = r_op ? 32'h0 : (rd_val & r_mask);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_accepted   <= r_acc;
            r_rdata      <= res_rdata;
            r_meip_clear <= !r_op && r_level && (r_region == REG_CLAIM);
        end
    end

`ifndef NO_ASSERTIONS
    a_clear_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_meip_clear) |-> o_accepted)
        else $error("line clear on a refused item");
    a_refused_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_accepted) |-> ((o_rdata == 32'h0) && !o_meip_clear))
        else $error("refused item carries data");
    a_claim_id_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_meip_clear) |-> (o_rdata < 32'(NUM_SOURCES)))
        else $error("claim id out of range");
    a_scan_skips_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_scan_addr != '0))
        else $error("scan reached source zero");
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && i_stall) |=> (r_state == S_DONE))
        else $error("result dropped while output stalled");
`endif

endmodule

@@ bench/plic_claim_complete_regs_top_test.sv @@
// self-checking testbench for the claim/complete interrupt controller register window
module plic_claim_complete_regs_top_test;
    import pcc_pkg::*;

    typedef enum bit {ACC_READ = 1'b0, ACC_WRITE = 1'b1} t_acc_op;

    typedef struct {
        t_acc_op    op;
        bit [23:0]  offset;
        bit [3:0]   length;
        bit [31:0]  wdata;
        bit         meip_level;
    } t_access;

    typedef struct {
        bit         accepted;
        bit [31:0]  rdata;
        bit         meip_clear;
    } t_response;

    class plic_reg_scoreboard;
        bit [PRI_STORE_W-1:0] prio_mem[NUM_SOURCES];
        bit [31:0]            enable_word;
        bit [31:0]            threshold_word;
        bit [31:0]            pending_word;
        bit [SRC_W-1:0]       in_service;
        t_response            expected_results[$];
        int                   mismatch_count;

        function bit in_window(bit [23:0] offset, bit [3:0] length);
            return offset[1:0] == 2'b00 && (25'(offset) + 25'(length)) <= WINDOW_SIZE;
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            mismatch_count++;
        endtask

        // lowest id wins ties since only a strictly higher priority replaces the pick
        function bit [SRC_W-1:0] arbitrate();
            bit [31:0]      lead_pri;
            bit [SRC_W-1:0] best;
            lead_pri = threshold_word;
            best = '0;
            for (int s = 1; s < NUM_SOURCES; s++) begin
                if (enable_word[s] && 32'(prio_mem[s][PRI_W-1:0]) > lead_pri) begin
                    lead_pri = 32'(prio_mem[s][PRI_W-1:0]);
                    best = SRC_W'(s);
                end
            end
            return best;
        endfunction

        function void note_access(t_access a);
            t_response r;
            bit [31:0] mask;
            bit [31:0] value;
            int        idx;
            r = '{default: 0};
            value = '0;
            mask = (a.length >= 4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * a.length)) - 32'd1);
            idx = (a.offset >> 2) % NUM_SOURCES;
            if (in_window(a.offset, a.length)) begin
                r.accepted = 1'b1;
                if (a.op == ACC_READ) begin
                    if (a.offset == CLAIM_OFF) begin
                        if (a.meip_level) begin
                            in_service = arbitrate();
                            r.meip_clear = 1'b1;
                            value = 32'(in_service);
                        end
                    end else if (a.offset < PRIO_END) begin
                        value = 32'(prio_mem[idx]);
                    end else if (a.offset == PENDING_OFF) begin
                        value = pending_word;
                    end else if (a.offset == ENABLE_OFF) begin
                        value = enable_word;
                    end else if (a.offset == THRESHOLD_OFF) begin
                        value = threshold_word;
                    end
                    r.rdata = value & mask;
                end else begin
                    value = a.wdata & mask;
                    if (a.offset == CLAIM_OFF) begin
                        if (value == 32'(in_service))
                            in_service = '0;
                    end else if (a.offset < PRIO_END) begin
                        prio_mem[idx] = value[PRI_STORE_W-1:0];
                    end else if (a.offset == PENDING_OFF) begin
                        pending_word = value;
                    end else if (a.offset == ENABLE_OFF) begin
                        enable_word = value;
                    end else if (a.offset == THRESHOLD_OFF) begin
                        threshold_word = value;
                    end
                end
            end
            expected_results.push_back(r);
        endfunction

        task check_response(t_response got);
            t_response want;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected: acc=%0d rdata=%h clr=%0d",
                                          got.accepted, got.rdata, got.meip_clear));
                return;
            end
            want = expected_results.pop_front();
            if (got.accepted != want.accepted)
                report_mismatch($sformatf("accepted %0d, expected %0d",
                                          got.accepted, want.accepted));
            if (got.rdata != want.rdata)
                report_mismatch($sformatf("rdata %h, expected %h", got.rdata, want.rdata));
            if (got.meip_clear != want.meip_clear)
                report_mismatch($sformatf("meip_clear %0d, expected %0d",
                                          got.meip_clear, want.meip_clear));
        endtask

        task flush_leftovers();
            if (expected_results.size() != 0)
                report_mismatch($sformatf("%0d expected items never came",
                                          expected_results.size()));
        endtask
    endclass

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic        i_op         = 1'b0;
    logic [23:0] i_offset     = '0;
    logic [3:0]  i_length     = '0;
    logic [31:0] i_wdata      = '0;
    logic        i_meip_level = 1'b0;
    logic        i_stall      = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic        o_accepted;
    logic [31:0] o_rdata;
    logic        o_meip_clear;

    bit tx_idles = 1'b1;
    bit rx_idles = 1'b1;

    plic_reg_scoreboard sb = new();

    plic_claim_complete_regs_top u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_op         (i_op),
        .i_offset     (i_offset),
        .i_length     (i_length),
        .i_wdata      (i_wdata),
        .i_meip_level (i_meip_level),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_accepted   (o_accepted),
        .o_rdata      (o_rdata),
        .o_meip_clear (o_meip_clear)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_stall <= i_rst_n && rx_idles && ($urandom_range(99) < 13);
    end

    always @(posedge i_clk) begin : monitor
        t_response got;
        t_access   acc;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                got.accepted   = o_accepted;
                got.rdata      = o_rdata;
                got.meip_clear = o_meip_clear;
                sb.check_response(got);
            end
            if (i_valid && !o_stall) begin
                acc.op         = t_acc_op'(i_op);
                acc.offset     = i_offset;
                acc.length     = i_length;
                acc.wdata      = i_wdata;
                acc.meip_level = i_meip_level;
                sb.note_access(acc);
            end
        end
    end

    function automatic t_access make_access(t_acc_op op, bit [23:0] offset, bit [3:0] length,
                                            bit [31:0] wdata, bit level);
        t_access a;
        a.op = op;
        a.offset = offset;
        a.length = length;
        a.wdata = wdata;
        a.meip_level = level;
        return a;
    endfunction

    function automatic t_access random_access();
        t_access a;
        int      pick;
        pick = $urandom_range(99);
        a.op = ACC_WRITE;
        a.length = ($urandom_range(4) != 0) ? 4'd4 : 4'($urandom_range(15));
        a.wdata = $urandom;
        a.meip_level = 1'($urandom_range(1));
        if (pick < 15) begin
            a.offset = 24'($urandom_range(NUM_SOURCES - 1) * 4);
        end else if (pick < 25) begin
            a.offset = ENABLE_OFF;
        end else if (pick < 35) begin
            a.offset = THRESHOLD_OFF;
            if ($urandom_range(3) != 0)
                a.wdata = $urandom_range(7);
        end else if (pick < 55) begin
            a.op = ACC_READ;
            a.offset = CLAIM_OFF;
            a.meip_level = ($urandom_range(9) != 0);
        end else if (pick < 70) begin
            a.offset = CLAIM_OFF;
            a.wdata = ($urandom_range(3) != 0) ? 32'(sb.in_service)
                                               : 32'($urandom_range(NUM_SOURCES - 1));
        end else if (pick < 80) begin
            a.op = ACC_READ;
            case ($urandom_range(3))
                0: a.offset = 24'($urandom_range(NUM_SOURCES - 1) * 4);
                1: a.offset = PENDING_OFF;
                2: a.offset = ENABLE_OFF;
                default: a.offset = THRESHOLD_OFF;
            endcase
        end else if (pick < 85) begin
            a.offset = PENDING_OFF;
        end else if (pick < 95) begin
            a.op = t_acc_op'($urandom_range(1));
            a.offset = 24'($urandom);
            a.length = 4'($urandom_range(15));
        end else begin
            // around the top of the window
            a.op = t_acc_op'($urandom_range(1));
            a.offset = 24'hFF_FFFF - 24'($urandom_range(11));
            a.length = 4'($urandom_range(15));
        end
        return a;
    endfunction

    task automatic send_access(t_access a);
        int gap;
        gap = 0;
        if (tx_idles)
            while ($urandom_range(99) < 13)
                gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_op         <= a.op;
        i_offset     <= a.offset;
        i_length     <= a.length;
        i_wdata      <= a.wdata;
        i_meip_level <= a.meip_level;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_results.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        #(64'd8 * 64'd400000);
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        t_access directed[$];
        t_access a;
        int      counted;
        int      n;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed.push_back(make_access(ACC_READ,  24'h00, 4'd4, 32'h0, 1'b0));
        directed.push_back(make_access(ACC_WRITE, 24'h00, 4'd4, 32'hFFFF_FFFF, 1'b1));
        directed.push_back(make_access(ACC_READ,  24'h00, 4'd4, 32'h0, 1'b1));
        directed.push_back(make_access(ACC_WRITE, 24'h04, 4'd4, 32'h5, 1'b0));
        directed.push_back(make_access(ACC_WRITE, 24'h08, 4'd2, 32'hABCD_0005, 1'b0));
        directed.push_back(make_access(ACC_WRITE, 24'h0C, 4'd1, 32'h0000_0107, 1'b1));
        directed.push_back(make_access(ACC_WRITE, 24'h10, 4'd4, 32'hF, 1'b0));
        directed.push_back(make_access(ACC_WRITE, 24'h1C, 4'd4, 32'h6, 1'b0));
        directed.push_back(make_access(ACC_WRITE, ENABLE_OFF, 4'd4, 32'hFFFF_FFFF, 1'b0));
        directed.push_back(make_access(ACC_READ,  CLAIM_OFF, 4'd4, 32'h0, 1'b0));
        directed.push_back(make_access(ACC_READ,  CLAIM_OFF, 4'd4, 32'h0, 1'b1));
        directed.push_back(make_access(ACC_WRITE, CLAIM_OFF, 4'd4, 32'h5, 1'b1));
        directed.push_back(make_access(ACC_WRITE, CLAIM_OFF, 4'd1, 32'h103, 1'b0));
        directed.push_back(make_access(ACC_WRITE, THRESHOLD_OFF, 4'd4, 32'h7, 1'b0));
        directed.push_back(make_access(ACC_READ,  CLAIM_OFF, 4'd4, 32'h0, 1'b1));
        directed.push_back(make_access(ACC_WRITE, THRESHOLD_OFF, 4'd8, 32'h100, 1'b0));
        directed.push_back(make_access(ACC_READ,  THRESHOLD_OFF, 4'd2, 32'h0, 1'b0));
        directed.push_back(make_access(ACC_WRITE, THRESHOLD_OFF, 4'd0, 32'h4, 1'b0));
        directed.push_back(make_access(ACC_READ,  CLAIM_OFF, 4'd0, 32'h0, 1'b1));
        directed.push_back(make_access(ACC_WRITE, PENDING_OFF, 4'd3, 32'hDEAD_BEEF, 1'b0));
        directed.push_back(make_access(ACC_READ,  PENDING_OFF, 4'd8, 32'h0, 1'b0));
        directed.push_back(make_access(ACC_READ,  ENABLE_OFF, 4'd1, 32'h0, 1'b0));
        directed.push_back(make_access(ACC_WRITE, 24'h20, 4'd4, 32'h1234_5678, 1'b0));
        directed.push_back(make_access(ACC_READ,  24'h20, 4'd4, 32'h0, 1'b0));
        directed.push_back(make_access(ACC_READ,  24'h00_0002, 4'd4, 32'h0, 1'b0));
        directed.push_back(make_access(ACC_WRITE, 24'hFF_FFFC, 4'd5, 32'hFFFF_FFFF, 1'b1));
        directed.push_back(make_access(ACC_READ,  24'hFF_FFFC, 4'd4, 32'h0, 1'b0));
        directed.push_back(make_access(ACC_READ,  24'hFF_FFF8, 4'd8, 32'h0, 1'b1));
        directed.push_back(make_access(ACC_READ,  24'hFF_FFFF, 4'd15, 32'h0, 1'b0));
        foreach (directed[k])
            send_access(directed[k]);
        drain_results();

        counted = 0;
        n = 0;
        while (counted < 500) begin
            tx_idles = !(counted >= 150 && counted < 250);
            rx_idles = tx_idles;
            a = random_access();
            if (sb.in_window(a.offset, a.length))
                counted++;
            send_access(a);
            n++;
            if (n % 120 == 119)
                drain_results();
        end
        i_valid <= 1'b0;

        for (int w = 0; w < 10000 && sb.expected_results.size() != 0; w++)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        sb.flush_leftovers();
        if (sb.mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
